@@ rtl/altshp_pkg.sv @@
// Package for the altitude stick shaper: shared types, codes and constants.
// Used by every module of the block; depends on nothing else.
package altshp_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned DIV_STEPS = 6;
	localparam int unsigned DIV_CNT_W = 3;

	localparam logic [2:0] REG_ROLL_LIMIT = 3'd0;
	localparam logic [2:0] REG_PITCH_LIMIT = 3'd1;
	localparam logic [2:0] REG_YAW_RATE_LIMIT = 3'd2;
	localparam logic [2:0] REG_EXPO_AMOUNT = 3'd3;
	localparam logic [2:0] REG_CLIMB_RATE_LIMIT = 3'd4;
	localparam logic [2:0] REG_CUT_WHEN_NEGATIVE = 3'd5;

	localparam logic [1:0] MODE_ALTITUDE = 2'd0;
	localparam logic [1:0] MODE_VELOCITY = 2'd1;
	localparam logic [1:0] MODE_THRUST = 2'd2;

	localparam logic [7:0] EXPO_FULL = 8'd255;
	localparam logic signed [18:0] DEADBAND_HIGH_X5 = 19'sd98304;
	localparam logic signed [18:0] DEADBAND_LOW_X5 = 19'sd65536;
	localparam logic [59:0] ROUND_HALF = 60'h0000000_0080_0000;
	localparam logic [35:0] NEG_MAG_MAX = 36'h0_8000_0000;
	localparam logic [35:0] POS_MAG_MAX = 36'h0_7FFF_FFFF;

	typedef struct packed {
		logic [7:0] roll_limit;
		logic [7:0] pitch_limit;
		logic [10:0] yaw_rate_limit;
		logic [7:0] expo_amount;
		logic [15:0] climb_rate_limit;
		logic cut_when_negative;
	} cfg_t;

	typedef enum logic [1:0] {
		CASE_CUT,
		CASE_CLIMB,
		CASE_DESCENT,
		CASE_HOLD
	} thr_case_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_K,
		ST_MUL_C1,
		ST_MUL_C2,
		ST_LIN,
		ST_SUM,
		ST_DIV,
		ST_SCALE,
		ST_COMMIT,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_MUL_K,
		OP_MUL_C1,
		OP_MUL_C2,
		OP_LIN,
		OP_SUM,
		OP_DIV,
		OP_SCALE,
		OP_COMMIT
	} op_t;

	typedef struct packed {
		logic load;
		op_t op;
		logic out_load;
	} cmd_t;

endpackage

@@ rtl/altshp_if.sv @@
// Handshake interfaces for the stick sample channel and the result channel.
// Field widths follow the block's word formats; no package dependency.
interface altshp_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] stick_roll;
	logic signed [15:0] stick_pitch;
	logic signed [15:0] stick_yaw;
	logic signed [15:0] stick_thrust;
	logic vario_mode;
	logic first_call;
	logic signed [31:0] down_position;

	modport source (
		output valid, stick_roll, stick_pitch, stick_yaw, stick_thrust,
		output vario_mode, first_call, down_position,
		input ready
	);
	modport sink (
		input valid, stick_roll, stick_pitch, stick_yaw, stick_thrust,
		input vario_mode, first_call, down_position,
		output ready
	);
endinterface

interface altshp_out_if;
	logic valid;
	logic ready;
	logic signed [23:0] roll_target;
	logic signed [23:0] pitch_target;
	logic signed [26:0] yaw_target;
	logic signed [31:0] setpoint;
	logic [1:0] control_mode;

	modport source (
		output valid, roll_target, pitch_target, yaw_target, setpoint, control_mode,
		input ready
	);
	modport sink (
		input valid, roll_target, pitch_target, yaw_target, setpoint, control_mode,
		output ready
	);
endinterface

@@ rtl/altitude_stick_shaper_core.sv @@
// Altitude stick shaper top level: configuration port, controller and datapath.
// Depends on altshp_pkg, altshp_if, altshp_cfg, altshp_ctrl and altshp_dp.
//
// Each word on sample_in is one stick sample; each produces exactly one word on
// result_out with the roll, pitch and yaw commands and the thrust setpoint and mode.
// The user must write registers over the APB-style port only while no word is in
// flight; the block does not enforce this. A word is accepted only when the block
// is idle; the next word is accepted once the previous result has been loaded into
// the output register. The controller's sequence for each word is: four passes
// through the shared 43x18 multiplier for the expo curve, one wide add, six byte
// steps of the divide by 255, one scaling multiply and one commit step.
// The result sits in an output register, so a new sample is taken while the
// previous result waits; if the receiver still stalls when the next result is
// ready, the controller holds it in its final state until the output frees.
// Reset restores the register defaults, clears the output valid, arms the
// altitude capture and sets the held setpoint to zero in altitude mode.
module altitude_stick_shaper_core (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [altshp_pkg::ADDR_W-1:0] paddr,
	input logic [altshp_pkg::DATA_W-1:0] pwdata,
	output logic [altshp_pkg::DATA_W-1:0] prdata,
	output logic pready,
	altshp_in_if.sink sample_in,
	altshp_out_if.source result_out
);

	altshp_pkg::cfg_t cfg;
	altshp_pkg::cmd_t cmd;
	logic in_ready;
	logic out_valid;

	assign sample_in.ready = in_ready;
	assign result_out.valid = out_valid;

	altshp_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	altshp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sample_in.valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(result_out.ready),
		.cmd(cmd)
	);

	altshp_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd(cmd),
		.sample_in(sample_in),
		.result_out(result_out)
	);

endmodule

@@ rtl/altshp_cfg.sv @@
// APB-style register file holding the shaper's six configuration registers.
// Depends on altshp_pkg for the register indexes and the cfg_t type.
module altshp_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [altshp_pkg::ADDR_W-1:0] paddr,
	input logic [altshp_pkg::DATA_W-1:0] pwdata,
	output logic [altshp_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output altshp_pkg::cfg_t cfg
);

	altshp_pkg::cfg_t cfg_q;
	logic wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign idx = paddr[4:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roll_limit <= 8'd55;
			cfg_q.pitch_limit <= 8'd55;
			cfg_q.yaw_rate_limit <= 11'd150;
			cfg_q.expo_amount <= 8'd128;
			cfg_q.climb_rate_limit <= 16'd1280;
			cfg_q.cut_when_negative <= 1'b1;
		end else if (wr_en) begin
			unique case (idx)
				altshp_pkg::REG_ROLL_LIMIT: cfg_q.roll_limit <= pwdata[7:0];
				altshp_pkg::REG_PITCH_LIMIT: cfg_q.pitch_limit <= pwdata[7:0];
				altshp_pkg::REG_YAW_RATE_LIMIT: cfg_q.yaw_rate_limit <= pwdata[10:0];
				altshp_pkg::REG_EXPO_AMOUNT: cfg_q.expo_amount <= pwdata[7:0];
				altshp_pkg::REG_CLIMB_RATE_LIMIT: cfg_q.climb_rate_limit <= pwdata[15:0];
				altshp_pkg::REG_CUT_WHEN_NEGATIVE: cfg_q.cut_when_negative <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			altshp_pkg::REG_ROLL_LIMIT: prdata = {24'b0, cfg_q.roll_limit};
			altshp_pkg::REG_PITCH_LIMIT: prdata = {24'b0, cfg_q.pitch_limit};
			altshp_pkg::REG_YAW_RATE_LIMIT: prdata = {21'b0, cfg_q.yaw_rate_limit};
			altshp_pkg::REG_EXPO_AMOUNT: prdata = {24'b0, cfg_q.expo_amount};
			altshp_pkg::REG_CLIMB_RATE_LIMIT: prdata = {16'b0, cfg_q.climb_rate_limit};
			altshp_pkg::REG_CUT_WHEN_NEGATIVE: prdata = {31'b0, cfg_q.cut_when_negative};
			default: prdata = '0;
		endcase
	end

endmodule

@@ rtl/altshp_ctrl.sv @@
// Controller state machine that sequences one stick word through the datapath.
// Depends on altshp_pkg for the state, operation and command types.
module altshp_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output altshp_pkg::cmd_t cmd
);

	altshp_pkg::state_t state_q;
	altshp_pkg::state_t state_d;
	logic [altshp_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic out_valid_q;
	logic out_free;

	assign in_ready = (state_q == altshp_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= altshp_pkg::ST_IDLE;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == altshp_pkg::ST_SUM) begin
				div_cnt_q <= '0;
			end else if (state_q == altshp_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.load = 1'b0;
		cmd.op = altshp_pkg::OP_NONE;
		cmd.out_load = 1'b0;
		unique case (state_q)
			altshp_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = altshp_pkg::ST_MUL_K;
				end
			end
			altshp_pkg::ST_MUL_K: begin
				cmd.op = altshp_pkg::OP_MUL_K;
				state_d = altshp_pkg::ST_MUL_C1;
			end
			altshp_pkg::ST_MUL_C1: begin
				cmd.op = altshp_pkg::OP_MUL_C1;
				state_d = altshp_pkg::ST_MUL_C2;
			end
			altshp_pkg::ST_MUL_C2: begin
				cmd.op = altshp_pkg::OP_MUL_C2;
				state_d = altshp_pkg::ST_LIN;
			end
			altshp_pkg::ST_LIN: begin
				cmd.op = altshp_pkg::OP_LIN;
				state_d = altshp_pkg::ST_SUM;
			end
			altshp_pkg::ST_SUM: begin
				cmd.op = altshp_pkg::OP_SUM;
				state_d = altshp_pkg::ST_DIV;
			end
			altshp_pkg::ST_DIV: begin
				cmd.op = altshp_pkg::OP_DIV;
				if (div_cnt_q == altshp_pkg::DIV_CNT_W'(altshp_pkg::DIV_STEPS - 1)) begin
					state_d = altshp_pkg::ST_SCALE;
				end
			end
			altshp_pkg::ST_SCALE: begin
				cmd.op = altshp_pkg::OP_SCALE;
				state_d = altshp_pkg::ST_COMMIT;
			end
			altshp_pkg::ST_COMMIT: begin
				cmd.op = altshp_pkg::OP_COMMIT;
				state_d = altshp_pkg::ST_OUT;
			end
			altshp_pkg::ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = altshp_pkg::ST_IDLE;
				end
			end
			default: state_d = altshp_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ rtl/altshp_dp.sv @@
// Datapath: stick scaling, cubic expo through one shared multiplier, a
// byte-serial divide by 255, setpoint selection and the held state.
// Depends on altshp_pkg and on the altshp_in_if and altshp_out_if interfaces.
module altshp_dp (
	input logic clk,
	input logic arst_n,
	input altshp_pkg::cfg_t cfg,
	input altshp_pkg::cmd_t cmd,
	altshp_in_if.sink sample_in,
	altshp_out_if.source result_out
);

	logic signed [15:0] roll_in_q;
	logic signed [15:0] pitch_in_q;
	logic signed [15:0] yaw_in_q;
	logic signed [15:0] thrust_q;
	logic [31:0] down_q;
	logic first_q;
	altshp_pkg::thr_case_t case_q;
	logic [16:0] mc_q;
	logic [17:0] ml_q;
	logic [58:0] acc_q;
	logic [25:0] lin_q;
	logic [47:0] g_q;
	logic [7:0] rem_q;
	logic [23:0] roll_t_q;
	logic [23:0] pitch_t_q;
	logic [26:0] yaw_t_q;
	logic [31:0] held_sp_q;
	logic [1:0] held_mode_q;
	logic pending_q;
	logic [23:0] roll_o_q;
	logic [23:0] pitch_o_q;
	logic [26:0] yaw_o_q;
	logic [31:0] sp_o_q;
	logic [1:0] mode_o_q;

	logic signed [15:0] t_in;
	logic signed [18:0] r5;
	logic signed [18:0] hi_diff;
	logic signed [18:0] lo_diff;
	altshp_pkg::thr_case_t case_d;
	logic [16:0] mc_d;
	logic [17:0] ml_d;

	logic [42:0] mul_a;
	logic [17:0] mul_b;
	logic [60:0] prod;
	logic signed [15:0] sm_a;
	logic [10:0] sm_b;
	logic signed [27:0] sm_prod;

	logic [59:0] sum_w;
	logic [15:0] acc16;
	logic [16:0] qsum;
	logic [7:0] qd;
	logic [15:0] rem_w;
	logic [59:0] rnd;
	logic [35:0] mag;
	logic [35:0] mag_neg;
	logic [35:0] mag_pos;
	logic pend;
	logic [31:0] sp_d;
	logic [1:0] mode_d;
	logic pend_d;

	assign t_in = sample_in.stick_thrust;
	assign r5 = {{3{t_in[15]}}, t_in} + {t_in[15], t_in, 2'b00};
	assign hi_diff = r5 - altshp_pkg::DEADBAND_HIGH_X5;
	assign lo_diff = altshp_pkg::DEADBAND_LOW_X5 - r5;

	always_comb begin
		case_d = altshp_pkg::CASE_HOLD;
		mc_d = '0;
		ml_d = '0;
		if (cfg.cut_when_negative && t_in[15]) begin
			case_d = altshp_pkg::CASE_CUT;
		end else if (sample_in.vario_mode && (r5 > altshp_pkg::DEADBAND_HIGH_X5)) begin
			case_d = altshp_pkg::CASE_CLIMB;
			mc_d = hi_diff[16:0];
			ml_d = {1'b0, hi_diff[16:0]};
		end else if (sample_in.vario_mode && (r5 < altshp_pkg::DEADBAND_LOW_X5)) begin
			case_d = altshp_pkg::CASE_DESCENT;
			mc_d = t_in[15] ? 17'h10000 : lo_diff[16:0];
			ml_d = lo_diff[17:0];
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			altshp_pkg::OP_MUL_K: begin
				mul_a = {35'b0, cfg.expo_amount};
				mul_b = {1'b0, mc_q};
			end
			altshp_pkg::OP_MUL_C1, altshp_pkg::OP_MUL_C2: begin
				mul_a = acc_q[42:0];
				mul_b = {1'b0, mc_q};
			end
			altshp_pkg::OP_LIN: begin
				mul_a = {35'b0, altshp_pkg::EXPO_FULL - cfg.expo_amount};
				mul_b = ml_q;
			end
			altshp_pkg::OP_SCALE: begin
				mul_a = g_q[42:0];
				mul_b = {2'b0, cfg.climb_rate_limit};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = {18'b0, mul_a} * {43'b0, mul_b};

	always_comb begin
		sm_a = roll_in_q;
		sm_b = {3'b0, cfg.roll_limit};
		unique case (cmd.op)
			altshp_pkg::OP_MUL_C1: begin
				sm_a = pitch_in_q;
				sm_b = {3'b0, cfg.pitch_limit};
			end
			altshp_pkg::OP_MUL_C2: begin
				sm_a = yaw_in_q;
				sm_b = cfg.yaw_rate_limit;
			end
			default: begin
				sm_a = roll_in_q;
				sm_b = {3'b0, cfg.roll_limit};
			end
		endcase
	end

	assign sm_prod = sm_a * $signed({1'b0, sm_b});

	assign sum_w = {1'b0, acc_q} + {2'b0, lin_q, 32'b0};

	// One quotient byte per step; x/255 for x below 65535 is (x + 1 + x/256) / 256.
	assign acc16 = {rem_q, g_q[47:40]};
	assign qsum = {1'b0, acc16} + 17'd1 + {9'b0, acc16[15:8]};
	assign qd = qsum[15:8];
	assign rem_w = acc16 - ({qd, 8'b0} - {8'b0, qd});

	assign rnd = {1'b0, acc_q} + altshp_pkg::ROUND_HALF;
	assign mag = rnd[59:24];
	assign mag_neg = (mag > altshp_pkg::NEG_MAG_MAX) ? altshp_pkg::NEG_MAG_MAX : mag;
	assign mag_pos = (mag > altshp_pkg::POS_MAG_MAX) ? altshp_pkg::POS_MAG_MAX : mag;
	assign pend = pending_q | first_q;

	always_comb begin
		sp_d = held_sp_q;
		mode_d = held_mode_q;
		pend_d = pend;
		unique case (case_q)
			altshp_pkg::CASE_CUT: begin
				sp_d = {{15{thrust_q[15]}}, thrust_q, 1'b0};
				mode_d = altshp_pkg::MODE_THRUST;
				pend_d = 1'b1;
			end
			altshp_pkg::CASE_CLIMB: begin
				sp_d = 32'd0 - mag_neg[31:0];
				mode_d = altshp_pkg::MODE_VELOCITY;
				pend_d = 1'b1;
			end
			altshp_pkg::CASE_DESCENT: begin
				sp_d = mag_pos[31:0];
				mode_d = altshp_pkg::MODE_VELOCITY;
				pend_d = 1'b1;
			end
			altshp_pkg::CASE_HOLD: begin
				if (pend) begin
					sp_d = down_q;
					mode_d = altshp_pkg::MODE_ALTITUDE;
					pend_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_sp_q <= '0;
			held_mode_q <= altshp_pkg::MODE_ALTITUDE;
			pending_q <= 1'b1;
		end else if (cmd.op == altshp_pkg::OP_COMMIT) begin
			held_sp_q <= sp_d;
			held_mode_q <= mode_d;
			pending_q <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			roll_in_q <= sample_in.stick_roll;
			pitch_in_q <= sample_in.stick_pitch;
			yaw_in_q <= sample_in.stick_yaw;
			thrust_q <= t_in;
			down_q <= sample_in.down_position;
			first_q <= sample_in.first_call;
			case_q <= case_d;
			mc_q <= mc_d;
			ml_q <= ml_d;
		end
		unique case (cmd.op)
			altshp_pkg::OP_MUL_K: begin
				acc_q <= prod[58:0];
				roll_t_q <= sm_prod[23:0];
			end
			altshp_pkg::OP_MUL_C1: begin
				acc_q <= prod[58:0];
				pitch_t_q <= sm_prod[23:0];
			end
			altshp_pkg::OP_MUL_C2: begin
				acc_q <= prod[58:0];
				yaw_t_q <= sm_prod[26:0];
			end
			altshp_pkg::OP_LIN: lin_q <= prod[25:0];
			altshp_pkg::OP_SUM: begin
				g_q <= {5'b0, sum_w[58:16]};
				rem_q <= '0;
			end
			altshp_pkg::OP_DIV: begin
				g_q <= {g_q[39:0], qd};
				rem_q <= rem_w[7:0];
			end
			altshp_pkg::OP_SCALE: acc_q <= prod[58:0];
			default: ;
		endcase
		if (cmd.out_load) begin
			roll_o_q <= roll_t_q;
			pitch_o_q <= pitch_t_q;
			yaw_o_q <= yaw_t_q;
			sp_o_q <= held_sp_q;
			mode_o_q <= held_mode_q;
		end
	end

	assign result_out.roll_target = roll_o_q;
	assign result_out.pitch_target = pitch_o_q;
	assign result_out.yaw_target = yaw_o_q;
	assign result_out.setpoint = sp_o_q;
	assign result_out.control_mode = mode_o_q;

endmodule
